// ===== rtl/core/swa_pkg.sv =====
package swa_pkg;

	localparam int unsigned MaxSamplesDef = 1024;
	localparam int unsigned TempW = 12;
	localparam int unsigned HumW = 10;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_REPORT = 2'd1,
		CMD_ALIVE  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	localparam logic RES_REPORT = 1'b0;
	localparam logic RES_ALIVE  = 1'b1;

	typedef struct packed {
		logic                    poll_ok;
		logic                    temp_ok;
		logic signed [TempW-1:0] temp_tenths;
		logic                    hum_ok;
		logic [HumW-1:0]         hum_tenths;
	} sample_t;

	typedef struct packed {
		logic sample_en;
		logic clr_win;
		logic clr_err;
	} acc_ctrl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ===== rtl/core/swa_accum.sv =====
module swa_accum import swa_pkg::*; #(
	parameter int unsigned MAX_SAMPLES = MaxSamplesDef,
	localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1),
	localparam int unsigned TSumW = TempW + CntW,
	localparam int unsigned HSumW = HumW + CntW
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  acc_ctrl_t               ctrl,
	input  sample_t                 smp,
	output logic signed [TSumW-1:0] temp_sum,
	output logic [CntW-1:0]         temp_cnt,
	output logic [HSumW-1:0]        hum_sum,
	output logic [CntW-1:0]         hum_cnt,
	output logic                    err_zero
);

	logic signed [TSumW-1:0] temp_sum_q;
	logic [CntW-1:0]         temp_cnt_q;
	logic [HSumW-1:0]        hum_sum_q;
	logic [CntW-1:0]         hum_cnt_q;
	logic [15:0]             err_q;

	logic        temp_add, hum_add, temp_err, hum_err;
	logic [1:0]  err_inc;
	logic [16:0] err_sum;
	logic [15:0] err_next;

	assign temp_add = ctrl.sample_en && smp.poll_ok && smp.temp_ok
		&& (temp_cnt_q < CntW'(MAX_SAMPLES));
	assign hum_add = ctrl.sample_en && smp.poll_ok && smp.hum_ok
		&& (hum_cnt_q < CntW'(MAX_SAMPLES));
	assign temp_err = ctrl.sample_en && smp.poll_ok && !smp.temp_ok;
	assign hum_err = ctrl.sample_en && smp.poll_ok && !smp.hum_ok;

	// up to two errors per sample, count sticks at all ones
	assign err_inc = {1'b0, temp_err} + {1'b0, hum_err};
	assign err_sum = {1'b0, err_q} + 17'(err_inc);
	assign err_next = err_sum[16] ? 16'hffff : err_sum[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_sum_q <= '0;
			temp_cnt_q <= '0;
			hum_sum_q <= '0;
			hum_cnt_q <= '0;
			err_q <= '0;
		end else begin
			if (ctrl.clr_win) begin
				temp_sum_q <= '0;
				temp_cnt_q <= '0;
				hum_sum_q <= '0;
				hum_cnt_q <= '0;
			end else begin
				if (temp_add) begin
					temp_sum_q <= temp_sum_q + TSumW'(smp.temp_tenths);
					temp_cnt_q <= temp_cnt_q + CntW'(1);
				end
				if (hum_add) begin
					hum_sum_q <= hum_sum_q + HSumW'(smp.hum_tenths);
					hum_cnt_q <= hum_cnt_q + CntW'(1);
				end
			end
			if (ctrl.clr_err) begin
				err_q <= '0;
			end else if (ctrl.sample_en) begin
				err_q <= err_next;
			end
		end
	end

	assign temp_sum = temp_sum_q;
	assign temp_cnt = temp_cnt_q;
	assign hum_sum = hum_sum_q;
	assign hum_cnt = hum_cnt_q;
	assign err_zero = (err_q == '0);

endmodule

// ===== rtl/core/swa_serdiv.sv =====
module swa_serdiv import swa_pkg::*; #(
	parameter int unsigned DW = 22,
	parameter int unsigned CW = 11,
	localparam int unsigned StepW = $clog2(DW)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [CW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output div_stat_t     stat
);

	// restoring long division, one dividend bit in and one quotient bit out per cycle
	logic [DW-1:0]    dq_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    dvs_q;
	logic [StepW-1:0] step_q;
	logic             busy_q;
	logic             done_q;

	logic [CW:0] trial;
	logic [CW:0] diff;
	logic        ge;

	assign trial = {rem_q, dq_q[DW-1]};
	assign ge = (trial >= {1'b0, dvs_q});
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= StepW'(DW - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - StepW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dq_q <= {dq_q[DW-2:0], ge};
			rem_q <= ge ? diff[CW-1:0] : trial[CW-1:0];
		end
	end

	assign quotient = dq_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ===== rtl/core/sensor_window_averager.sv =====
// sensor window averager
// input beats on s_*: s_tuser carries the command (sample, report, alive query),
// s_tdata the poll and reading fields. result beats leave on m_*: m_tuser says
// whether the beat is a report or an alive answer.
// a sample beat goes straight into the accumulator and the block stays ready.
// an alive query answers via the emit state once the output register is free.
// a report runs two serial divisions on one shared restoring divider that
// retires one quotient bit per cycle; each covers 11 + clog2(MAX_SAMPLES + 1)
// dividend bits (22 at the default), and s_tready stays low until the report
// leaves the emit state for the output register.
// the output register holds one result; while it waits for m_tready the block
// still takes samples, and a further report or alive query finishes its work
// then holds in a pending stage until the output register frees up.
// reset clears sums, counts and the error count and empties the output.
module sensor_window_averager import swa_pkg::*; #(
	parameter int unsigned MAX_SAMPLES = MaxSamplesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// poll_ok, temp_ok, temp_tenths[11:0], hum_ok, hum_tenths[9:0], zero pad
	input  logic [31:0] s_tdata,
	// cmd[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// temp_avg[11:0], temp_sent, hum_avg[9:0], hum_sent, alive, zero pad
	output logic [31:0] m_tdata,
	// result_kind
	output logic        m_tuser
);

	localparam int unsigned CntW = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned TSumW = TempW + CntW;
	localparam int unsigned HSumW = HumW + CntW;
	localparam int unsigned DW = TempW - 1 + CntW;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_DIV_T = 4'b0010,
		ST_DIV_H = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t state_q;

	sample_t   smp;
	cmd_t      cmd;
	acc_ctrl_t actl;
	div_stat_t dstat;

	logic                    acc;
	logic signed [TSumW-1:0] temp_sum;
	logic [CntW-1:0]         temp_cnt;
	logic [HSumW-1:0]        hum_sum;
	logic [CntW-1:0]         hum_cnt;
	logic                    err_zero;

	logic                    temp_neg;
	logic [TSumW-1:0]        temp_mag;
	logic                    div_start;
	logic [DW-1:0]           div_dividend;
	logic [CntW-1:0]         div_divisor;
	logic [DW-1:0]           quotient;
	logic [TempW-1:0]        temp_q;
	logic [TempW-1:0]        temp_avg;
	logic                    out_free;

	logic             res_kind_q;
	logic [TempW-1:0] res_tavg_q;
	logic             res_tsent_q;
	logic [HumW-1:0]  res_havg_q;
	logic             res_hsent_q;
	logic             res_alive_q;

	logic        m_tvalid_q;
	logic [31:0] m_tdata_q;
	logic        m_tuser_q;

	assign smp.poll_ok = s_tdata[0];
	assign smp.temp_ok = s_tdata[1];
	assign smp.temp_tenths = s_tdata[13:2];
	assign smp.hum_ok = s_tdata[14];
	assign smp.hum_tenths = s_tdata[24:15];
	assign cmd = cmd_t'(s_tuser);

	assign s_tready = (state_q == ST_IDLE);
	assign acc = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign actl.sample_en = acc && (cmd == CMD_SAMPLE);
	assign actl.clr_err = acc && (cmd == CMD_ALIVE);
	assign actl.clr_win = (state_q == ST_DIV_H) && dstat.done;

	swa_accum #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (actl),
		.smp      (smp),
		.temp_sum (temp_sum),
		.temp_cnt (temp_cnt),
		.hum_sum  (hum_sum),
		.hum_cnt  (hum_cnt),
		.err_zero (err_zero)
	);

	// divide magnitudes, put the sign back on the truncated quotient
	assign temp_neg = temp_sum[TSumW-1];
	assign temp_mag = temp_neg ? -temp_sum : temp_sum;

	assign div_start = (acc && (cmd == CMD_REPORT)) || ((state_q == ST_DIV_T) && dstat.done);
	assign div_dividend = (state_q == ST_IDLE) ? temp_mag[DW-1:0] : DW'(hum_sum);
	assign div_divisor = (state_q == ST_IDLE) ? temp_cnt : hum_cnt;

	swa_serdiv #(
		.DW(DW),
		.CW(CntW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.stat     (dstat)
	);

	assign temp_q = quotient[TempW-1:0];
	assign temp_avg = temp_neg ? -temp_q : temp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						unique case (cmd)
							CMD_REPORT: state_q <= ST_DIV_T;
							CMD_ALIVE:  state_q <= ST_EMIT;
							CMD_SAMPLE: state_q <= ST_IDLE;
							CMD_NONE:   state_q <= ST_IDLE;
						endcase
					end
				end
				ST_DIV_T: begin
					if (dstat.done) begin
						state_q <= ST_DIV_H;
					end
				end
				ST_DIV_H: begin
					if (dstat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// pending result, set up on an alive or report beat and filled in as each division ends
	always_ff @(posedge clk) begin
		if (acc && (cmd == CMD_ALIVE)) begin
			res_kind_q <= RES_ALIVE;
			res_tavg_q <= '0;
			res_tsent_q <= 1'b0;
			res_havg_q <= '0;
			res_hsent_q <= 1'b0;
			res_alive_q <= err_zero;
		end else if (acc && (cmd == CMD_REPORT)) begin
			res_kind_q <= RES_REPORT;
			res_alive_q <= 1'b0;
		end else if ((state_q == ST_DIV_T) && dstat.done) begin
			res_tavg_q <= (temp_cnt == '0) ? '0 : temp_avg;
			res_tsent_q <= (temp_cnt != '0) && err_zero;
		end else if ((state_q == ST_DIV_H) && dstat.done) begin
			res_havg_q <= (hum_cnt == '0) ? '0 : quotient[HumW-1:0];
			res_hsent_q <= (hum_cnt != '0) && err_zero;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			m_tdata_q <= {7'b0, res_alive_q, res_hsent_q, res_havg_q, res_tsent_q, res_tavg_q};
			m_tuser_q <= res_kind_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;

	a_idle_div_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !dstat.busy)
		else $error("divider busy while idle");

	a_report_starts_div: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && (cmd == CMD_REPORT)) |=> ((state_q == ST_DIV_T) && dstat.busy))
		else $error("report beat did not start the divider");

	a_alive_fields_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == RES_ALIVE)) |-> (m_tdata[23:0] == '0))
		else $error("alive result carries average fields");

	a_report_no_alive: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == RES_REPORT)) |-> !m_tdata[24])
		else $error("report result carries alive flag");

	a_emit_loads: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_EMIT) && out_free) |=> (m_tvalid && (state_q == ST_IDLE)))
		else $error("pending result not moved to the output");

endmodule

// ===== tb/sv/sensor_window_averager_tb.sv =====
`timescale 1ns / 1ps

module sensor_window_averager_tb;
	import swa_pkg::*;

	localparam int unsigned WindowCap = MaxSamplesDef;
	localparam int unsigned ErrCeil = 65535;
	localparam int unsigned HoldCycles = 400;

	typedef struct {
		cmd_t                    cmd;
		bit                      poll_ok;
		bit                      temp_ok;
		logic signed [TempW-1:0] temp;
		bit                      hum_ok;
		logic [HumW-1:0]         hum;
	} reading_t;

	typedef struct {
		logic                    kind;
		logic signed [TempW-1:0] temp_avg;
		logic                    temp_sent;
		logic [HumW-1:0]         hum_avg;
		logic                    hum_sent;
		logic                    alive;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = CMD_NONE;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;
	logic        m_tuser;

	reading_t pending_readings[$];
	answer_t  expected_answers[$];
	reading_t on_bus;
	answer_t  head;

	// window state of the predictor
	int          win_temp_sum;
	int unsigned win_temp_n;
	int unsigned win_hum_sum;
	int unsigned win_hum_n;
	int unsigned sensor_errs;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	bit          hold_req = 1'b0;
	bit          hold_done = 1'b0;
	int unsigned hold_left = 0;

	int unsigned beats_taken = 0;
	int unsigned answers_seen = 0;
	int unsigned fail_count = 0;

	sensor_window_averager u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("%0t: watchdog expired", $time);
		$display("FAIL");
		$finish;
	end

	function automatic reading_t mk_sample(bit p, bit tok, int t, bit hok, int h);
		reading_t r;
		r.cmd = CMD_SAMPLE;
		r.poll_ok = p;
		r.temp_ok = tok;
		r.temp = t[TempW-1:0];
		r.hum_ok = hok;
		r.hum = h[HumW-1:0];
		return r;
	endfunction

	function automatic reading_t mk_cmd(cmd_t c);
		reading_t r;
		r = mk_sample(1'b0, 1'b0, 0, 1'b0, 0);
		r.cmd = c;
		return r;
	endfunction

	function automatic logic [31:0] pack_reading(reading_t r);
		return {7'd0, r.hum, r.hum_ok, r.temp, r.temp_ok, r.poll_ok};
	endfunction

	function automatic void count_error();
		if (sensor_errs < ErrCeil)
			sensor_errs++;
	endfunction

	// advances the window state by one accepted beat and queues its answer, if any
	function automatic void track_window(reading_t r);
		answer_t a;
		a = '{kind: RES_REPORT, temp_avg: '0, temp_sent: 1'b0, hum_avg: '0,
			hum_sent: 1'b0, alive: 1'b0};
		case (r.cmd)
			CMD_SAMPLE: begin
				if (r.poll_ok) begin
					if (!r.temp_ok)
						count_error();
					else if (win_temp_n < WindowCap) begin
						win_temp_sum += int'(r.temp);
						win_temp_n++;
					end
					if (!r.hum_ok)
						count_error();
					else if (win_hum_n < WindowCap) begin
						win_hum_sum += int'(r.hum);
						win_hum_n++;
					end
				end
			end
			CMD_REPORT: begin
				if (win_temp_n != 0)
					a.temp_avg = TempW'(win_temp_sum / int'(win_temp_n));
				if (win_hum_n != 0)
					a.hum_avg = HumW'(win_hum_sum / win_hum_n);
				a.temp_sent = (win_temp_n != 0) && (sensor_errs == 0);
				a.hum_sent = (win_hum_n != 0) && (sensor_errs == 0);
				expected_answers.push_back(a);
				win_temp_sum = 0;
				win_temp_n = 0;
				win_hum_sum = 0;
				win_hum_n = 0;
			end
			CMD_ALIVE: begin
				a.kind = RES_ALIVE;
				a.alive = (sensor_errs == 0);
				expected_answers.push_back(a);
				sensor_errs = 0;
			end
			default: ;
		endcase
	endfunction

	function automatic void check_field(string what, int want, int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			fail_count++;
		end
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= CMD_NONE;
		end else begin
			if (s_tvalid && s_tready) begin
				track_window(on_bus);
				beats_taken++;
			end
			if (!s_tvalid || s_tready) begin
				if (pending_readings.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					on_bus = pending_readings.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= pack_reading(on_bus);
					s_tuser <= on_bus.cmd;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			m_tready <= 1'b0;
			hold_left <= HoldCycles;
			hold_done <= 1'b1;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_answers.size() == 0) begin
				$display("%0t: result beat with nothing expected, kind %0d data %h",
					$time, m_tuser, m_tdata);
				fail_count++;
			end else begin
				head = expected_answers.pop_front();
				check_field("result_kind", int'(head.kind), int'(m_tuser));
				check_field("temp_avg", int'(head.temp_avg), int'($signed(m_tdata[11:0])));
				check_field("temp_sent", int'(head.temp_sent), int'(m_tdata[12]));
				check_field("hum_avg", int'(head.hum_avg), int'(m_tdata[22:13]));
				check_field("hum_sent", int'(head.hum_sent), int'(m_tdata[23]));
				check_field("alive", int'(head.alive), int'(m_tdata[24]));
				answers_seen++;
			end
		end
	end

	task automatic drain();
		while (pending_readings.size() != 0 || s_tvalid || expected_answers.size() != 0)
			@(posedge clk);
	endtask

	function automatic int pick_temp();
		if ($urandom_range(9) == 0)
			return int'($signed(12'($urandom)));
		return int'($urandom_range(1650)) - 400;
	endfunction

	function automatic int pick_hum();
		if ($urandom_range(9) == 0)
			return int'($urandom_range(1023));
		return int'($urandom_range(1000));
	endfunction

	// mostly well-formed windows with the odd fault, query and stray code
	task automatic queue_random(int unsigned n);
		int unsigned roll;
		repeat (n) begin
			roll = $urandom_range(99);
			if (roll < 3)
				pending_readings.push_back(mk_cmd(CMD_NONE));
			else if (roll < 13)
				pending_readings.push_back(mk_cmd(CMD_REPORT));
			else if (roll < 19)
				pending_readings.push_back(mk_cmd(CMD_ALIVE));
			else
				pending_readings.push_back(mk_sample($urandom_range(19) != 0,
					$urandom_range(24) != 0, pick_temp(), $urandom_range(24) != 0, pick_hum()));
		end
	endtask

	initial begin
		win_temp_sum = 0;
		win_temp_n = 0;
		win_hum_sum = 0;
		win_hum_n = 0;
		sensor_errs = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty window, stray code, failed poll, range extremes, rounding
		pending_readings.push_back(mk_cmd(CMD_ALIVE));
		pending_readings.push_back(mk_cmd(CMD_REPORT));
		pending_readings.push_back(mk_cmd(CMD_NONE));
		pending_readings.push_back(mk_sample(1'b0, 1'b0, 2047, 1'b0, 1023));
		pending_readings.push_back(mk_cmd(CMD_ALIVE));
		pending_readings.push_back(mk_sample(1'b1, 1'b1, -400, 1'b1, 0));
		pending_readings.push_back(mk_sample(1'b1, 1'b1, 1250, 1'b1, 1000));
		pending_readings.push_back(mk_cmd(CMD_REPORT));
		pending_readings.push_back(mk_sample(1'b1, 1'b1, -7, 1'b1, 3));
		pending_readings.push_back(mk_sample(1'b1, 1'b1, -8, 1'b1, 4));
		pending_readings.push_back(mk_cmd(CMD_REPORT));
		pending_readings.push_back(mk_sample(1'b1, 1'b1, 2047, 1'b1, 1023));
		pending_readings.push_back(mk_sample(1'b1, 1'b1, -2048, 1'b1, 1023));
		pending_readings.push_back(mk_cmd(CMD_REPORT));
		pending_readings.push_back(mk_sample(1'b1, 1'b0, 100, 1'b1, 500));
		pending_readings.push_back(mk_cmd(CMD_REPORT));
		pending_readings.push_back(mk_cmd(CMD_ALIVE));
		pending_readings.push_back(mk_cmd(CMD_ALIVE));
		pending_readings.push_back(mk_sample(1'b1, 1'b1, 333, 1'b0, 512));
		pending_readings.push_back(mk_sample(1'b1, 1'b1, 334, 1'b1, 511));
		pending_readings.push_back(mk_cmd(CMD_REPORT));
		pending_readings.push_back(mk_cmd(CMD_ALIVE));
		drain();

		// overfull window: readings past the cap must be dropped
		send_idle_pct = 57;
		pending_readings.push_back(mk_cmd(CMD_ALIVE));
		repeat (WindowCap + 10)
			pending_readings.push_back(mk_sample(1'b1, 1'b1, pick_temp(), 1'b1, pick_hum()));
		pending_readings.push_back(mk_cmd(CMD_REPORT));
		drain();

		send_idle_pct = 0;
		queue_random(20);
		drain();
		send_idle_pct = 57;
		queue_random(20);
		drain();
		send_idle_pct = 0;
		recv_stall_pct = 57;
		queue_random(20);
		drain();
		send_idle_pct = 33;
		recv_stall_pct = 33;
		queue_random(20);
		drain();

		// back-pressure: receiver holds off while queries keep arriving
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pending_readings.push_back(mk_sample(1'b1, 1'b1, 200, 1'b1, 450));
		pending_readings.push_back(mk_cmd(CMD_REPORT));
		pending_readings.push_back(mk_cmd(CMD_ALIVE));
		pending_readings.push_back(mk_cmd(CMD_REPORT));
		pending_readings.push_back(mk_cmd(CMD_ALIVE));
		queue_random(20);
		hold_req = 1'b1;
		drain();

		repeat (100) @(posedge clk);
		$display("run covered %0d input beats and %0d checked results", beats_taken,
			answers_seen);
		$display("incl. overfull window, idle/stall phases and a long hold-off");
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
